// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the precompensation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Invariant that must hold at every rising clock edge outside reset.
`define FPWP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the next cycle.
`define FPWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define FPWP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/fpwp_pkg.sv =====
// Package with the shared types and constants of the write precompensation block.
`timescale 1ns / 1ps
`default_nettype none

package fpwp_pkg;

    localparam int PW_W       = 32;
    localparam int CORR_SHIFT = 3;

    // Command queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [PW_W-1:0] t_width;

    // Number of pulses held in the window.
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // Number of output beats carried by one command.
    localparam logic [1:0] NW_ONE   = 2'd1;
    localparam logic [1:0] NW_TWO   = 2'd2;
    localparam logic [1:0] NW_THREE = 2'd3;

    // One command: up to three finished pulse widths, in output order.
    typedef struct packed {
        logic [1:0] n_words;
        logic       fin;
        t_width     w0;
        t_width     w1;
        t_width     w2;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/fpwp_stream_if.sv =====
// Stream interfaces for the pulse input and the compensated pulse output.
`timescale 1ns / 1ps
`default_nettype none

interface fpwp_in_if import fpwp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_width pulse_width;
    logic   is_last;

    modport source (output valid, output pulse_width, output is_last, input ready);
    modport sink   (input valid, input pulse_width, input is_last, output ready);
endinterface

interface fpwp_out_if import fpwp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_width out_width;
    logic   out_last;

    modport source (output valid, output out_width, output out_last, input ready);
    modport sink   (input valid, input out_width, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fpwp_front.sv =====
// Front end: pulse window, precompensation arithmetic and command generation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fpwp_front import fpwp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_width i_width,
    input  wire logic   i_last,
    output logic        o_ready,
    input  wire logic   i_cmd_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam int CORR_W = PW_W + 1 - CORR_SHIFT;

    logic [1:0]        r_held, n_held;
    t_width            r_older, n_older;
    t_width            r_newer, n_newer;

    logic              accept;
    logic [PW_W:0]     outer;
    logic [PW_W:0]     twice;
    logic [PW_W:0]     diff;
    logic [CORR_W-1:0] corr;
    logic [CORR_W:0]   corr_inc;
    logic              do_adjust;
    t_width            a_adj, b_adj, c_adj;
    logic [PW_W:0]     sum_a, sum_c;

    assign accept  = i_valid && i_cmd_ready;
    assign o_ready = i_cmd_ready;

    // Window arithmetic: a is the older pulse, b the newer, c the incoming one.
    assign outer     = {1'b0, r_older} + {1'b0, i_width};
    assign twice     = {r_newer, 1'b0};
    assign diff      = outer - twice;
    assign corr      = diff[PW_W:CORR_SHIFT];
    assign corr_inc  = {1'b0, corr} + {{CORR_W{1'b0}}, 1'b1};
    assign do_adjust = (twice < outer) && ({{CORR_SHIFT - 1{1'b0}}, corr} < r_newer);

    assign sum_a = {1'b0, r_older} + {{(PW_W + 2 - CORR_W){1'b0}}, corr[CORR_W-1:1]};
    assign sum_c = {1'b0, i_width} + {{(PW_W + 1 - CORR_W){1'b0}}, corr_inc[CORR_W:1]};

    always_comb begin
        if (do_adjust) begin
            a_adj = sum_a[PW_W] ? {PW_W{1'b1}} : sum_a[PW_W-1:0];
            b_adj = r_newer - {{CORR_SHIFT - 1{1'b0}}, corr};
            c_adj = sum_c[PW_W] ? {PW_W{1'b1}} : sum_c[PW_W-1:0];
        end else begin
            a_adj = r_older;
            b_adj = r_newer;
            c_adj = i_width;
        end
    end

    always_comb begin
        n_held  = r_held;
        n_older = r_older;
        n_newer = r_newer;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (accept) begin
            case (r_held)
                HELD_NONE: begin
                    if (i_last) begin
                        o_push        = 1'b1;
                        o_cmd.n_words = NW_ONE;
                        o_cmd.fin     = 1'b1;
                        o_cmd.w0      = i_width;
                    end else begin
                        n_older = i_width;
                        n_held  = HELD_ONE;
                    end
                end
                HELD_ONE: begin
                    if (i_last) begin
                        o_push        = 1'b1;
                        o_cmd.n_words = NW_TWO;
                        o_cmd.fin     = 1'b1;
                        o_cmd.w0      = r_older;
                        o_cmd.w1      = i_width;
                        n_older       = '0;
                        n_held        = HELD_NONE;
                    end else begin
                        n_newer = i_width;
                        n_held  = HELD_TWO;
                    end
                end
                default: begin
                    o_push   = 1'b1;
                    o_cmd.w0 = a_adj;
                    if (i_last) begin
                        o_cmd.n_words = NW_THREE;
                        o_cmd.fin     = 1'b1;
                        o_cmd.w1      = b_adj;
                        o_cmd.w2      = c_adj;
                        n_older       = '0;
                        n_newer       = '0;
                        n_held        = HELD_NONE;
                    end else begin
                        o_cmd.n_words = NW_ONE;
                        n_older       = b_adj;
                        n_newer       = c_adj;
                        n_held        = HELD_TWO;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= HELD_NONE;
            r_older <= '0;
            r_newer <= '0;
        end else begin
            r_held  <= n_held;
            r_older <= n_older;
            r_newer <= n_newer;
        end
    end

    `FPWP_ASSERT_NEXT(a_last_flushes, i_clk, i_rst_n, accept && i_last, r_held == HELD_NONE, "window not empty after last pulse")

endmodule

`default_nettype wire

// ===== rtl/core/fpwp_queue.sv =====
// Short command queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fpwp_queue import fpwp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_head
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `FPWP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QDEPTH), "queue count overflow")
    `FPWP_ASSERT(a_ptr_track, i_clk, i_rst_n, r_wr_ptr == QPTR_W'(r_rd_ptr + r_count), "queue pointers and count disagree")

endmodule

`default_nettype wire

// ===== rtl/core/fpwp_back.sv =====
// Back end: plays out each queued command as one to three output beats.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fpwp_back import fpwp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_head_valid,
    input  wire t_cmd   i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_width      o_width,
    output logic        o_last
);

    logic [1:0] r_beat;
    logic       final_beat;
    logic       accept;

    assign final_beat = (r_beat == (i_head.n_words - 2'd1));
    assign accept     = o_valid && i_ready;
    assign o_valid    = i_head_valid;
    assign o_last     = i_head.fin && final_beat;
    assign o_pop      = accept && final_beat;

    always_comb begin
        case (r_beat)
            2'd0:    o_width = i_head.w0;
            2'd1:    o_width = i_head.w1;
            default: o_width = i_head.w2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (o_pop) begin
            r_beat <= '0;
        end else if (accept) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    `FPWP_ASSERT(a_beat_in_cmd, i_clk, i_rst_n, !i_head_valid || (r_beat < i_head.n_words), "beat index past end of command")
    `FPWP_ASSERT(a_beat_idle, i_clk, i_rst_n, i_head_valid || (r_beat == 2'd0), "beat index left over with empty queue")

endmodule

`default_nettype wire

// ===== rtl/core/flux_pulse_write_precomp.sv =====
// Top level of the flux pulse write precompensation block.
`timescale 1ns / 1ps
`default_nettype none

//  Port     | Dir | Beat payload               | Meaning
//  ---------+-----+----------------------------+------------------------------------
//  i_pulse  | in  | pulse_width[31:0], is_last | raw flux pulse width, end of track
//  o_comp   | out | out_width[31:0], out_last  | compensated width, end of track
//
// An input beat is taken every cycle while the command queue has room; the window
// arithmetic (wide adds, compares, subtracts and a shift) closes in that same cycle.
// Results leave one beat per cycle while o_comp is ready, registered in the queue first,
// so a steady stream runs at one pulse per cycle; a track end produces up to three beats.
// A four-entry command queue decouples the two sides, so either can stall alone.
// Reset (synchronous, active low) empties the window, the queue and the beat counter.

module flux_pulse_write_precomp import fpwp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fpwp_in_if.sink    i_pulse,
    fpwp_out_if.source o_comp
);

    logic q_full;
    logic q_push;
    t_cmd q_cmd;
    logic q_valid;
    t_cmd q_head;
    logic q_pop;

    // Front end: holds the two-pulse window and builds commands from the accepted beats.
    fpwp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pulse.valid),
        .i_width     (i_pulse.pulse_width),
        .i_last      (i_pulse.is_last),
        .o_ready     (i_pulse.ready),
        .i_cmd_ready (!q_full),
        .o_push      (q_push),
        .o_cmd       (q_cmd)
    );

    // Commands carry finished widths, so the queue is the only coupling.
    fpwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Back end: serializes each command onto the output channel.
    fpwp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_comp.valid),
        .i_ready      (o_comp.ready),
        .o_width      (o_comp.out_width),
        .o_last       (o_comp.out_last)
    );

endmodule

`default_nettype wire

// ===== dv/tb_flux_pulse_write_precomp.sv =====
// Self-checking testbench of the flux pulse write precompensation block.
`timescale 1ns / 1ps

module tb_flux_pulse_write_precomp;
    import fpwp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        t_width width;
        logic   last;
    } t_comp_beat;

    // Shapes of the pulse widths inside one random track.
    typedef enum int {
        SHAPE_CELLS,
        SHAPE_ANY,
        SHAPE_NEAR_MAX,
        SHAPE_TINY
    } t_track_shape;

    logic i_clk;
    logic i_rst_n;

    fpwp_in_if  pulse_if ();
    fpwp_out_if comp_if ();

    flux_pulse_write_precomp u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pulse (pulse_if),
        .o_comp  (comp_if)
    );

    // Predicted window of adjusted pulses.
    t_width     win_older;
    t_width     win_newer;
    logic [1:0] win_held;

    t_comp_beat expected_beats[$];

    int fail_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_width sat_add(input t_width x, input t_width y);
        logic [PW_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[PW_W] ? '1 : s[PW_W-1:0];
    endfunction

    function automatic void push_beat(input t_width w, input logic last);
        t_comp_beat beat;
        beat.width = w;
        beat.last  = last;
        expected_beats.push_back(beat);
    endfunction

    // Advances the predicted window by one accepted pulse and queues its results.
    function automatic void predict_pulse(input t_width w, input logic last);
        logic [PW_W+1:0] outer;
        logic [PW_W+1:0] twice;
        t_width          a;
        t_width          b;
        t_width          c;
        t_width          corr;
        case (win_held)
            HELD_NONE: begin
                if (last) begin
                    push_beat(w, 1'b1);
                end else begin
                    win_older = w;
                    win_held  = HELD_ONE;
                end
            end
            HELD_ONE: begin
                if (last) begin
                    push_beat(win_older, 1'b0);
                    push_beat(w, 1'b1);
                    win_older = '0;
                    win_held  = HELD_NONE;
                end else begin
                    win_newer = w;
                    win_held  = HELD_TWO;
                end
            end
            default: begin
                a     = win_older;
                b     = win_newer;
                c     = w;
                outer = {2'b00, a} + {2'b00, c};
                twice = {1'b0, b, 1'b0};
                if (twice < outer) begin
                    corr = t_width'((outer - twice) >> CORR_SHIFT);
                    if (corr < b) begin
                        a = sat_add(a, corr >> 1);
                        b = b - corr;
                        c = sat_add(c, (corr + 1) >> 1);
                    end
                end
                push_beat(a, 1'b0);
                if (last) begin
                    push_beat(b, 1'b0);
                    push_beat(c, 1'b1);
                    win_older = '0;
                    win_newer = '0;
                    win_held  = HELD_NONE;
                end else begin
                    win_older = b;
                    win_newer = c;
                    win_held  = HELD_TWO;
                end
            end
        endcase
    endfunction

    // Offers one pulse beat; entered and left just after a falling edge.
    task automatic send_pulse(input t_width w, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pulse_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pulse_if.valid       <= 1'b1;
        pulse_if.pulse_width <= w;
        pulse_if.is_last     <= last;
        do @(posedge i_clk); while (!pulse_if.ready);
        predict_pulse(w, last);
        @(negedge i_clk);
    endtask

    // Stops offering, waits for every predicted beat, then lets the block settle.
    task automatic drain_results(input int settle);
        pulse_if.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_width pick_width(input t_track_shape shape, input int nominal);
        case (shape)
            SHAPE_CELLS:    return t_width'(nominal * $urandom_range(2, 4)
                                            + $urandom_range(0, nominal / 2) - nominal / 4);
            SHAPE_NEAR_MAX: return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 65535)
                                                        : $urandom_range(32'h4000_0000,
                                                                         32'h9FFF_FFFF);
            SHAPE_TINY:     return t_width'($urandom_range(0, 15));
            default:        return t_width'($urandom());
        endcase
    endfunction

    // Whole tracks with random length and content until about n_items pulses are sent.
    task automatic send_random_tracks(input int n_items);
        int           sent;
        int           len;
        int           roll;
        int           nominal;
        t_track_shape shape;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                len = $urandom_range(1, 2);
            end else if (roll < 90) begin
                len = $urandom_range(3, 12);
            end else begin
                len = $urandom_range(13, 40);
            end
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                shape = SHAPE_CELLS;
            end else if (roll < 8) begin
                shape = SHAPE_ANY;
            end else if (roll < 9) begin
                shape = SHAPE_NEAR_MAX;
            end else begin
                shape = SHAPE_TINY;
            end
            nominal = $urandom_range(16, 400);
            for (int k = 0; k < len; k++) begin
                send_pulse(pick_width(shape, nominal), k == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_short_tracks();
        send_pulse(32'h0000_0000, 1'b1);
        send_pulse(32'hFFFF_FFFF, 1'b1);
        send_pulse(32'd5, 1'b0);
        send_pulse(32'd7, 1'b1);
    endtask

    task automatic test_unadjusted_tracks();
        // The middle pulse is already at least the mean of its neighbors.
        send_pulse(32'd10, 1'b0);
        send_pulse(32'd20, 1'b0);
        send_pulse(32'd10, 1'b1);
        // The correction would not be smaller than the middle pulse.
        send_pulse(32'd1000, 1'b0);
        send_pulse(32'd1, 1'b0);
        send_pulse(32'd1000, 1'b1);
        send_pulse(32'd100, 1'b0);
        send_pulse(32'd0, 1'b0);
        send_pulse(32'd100, 1'b1);
    endtask

    task automatic test_adjusted_tracks();
        send_pulse(32'd100, 1'b0);
        send_pulse(32'd50, 1'b0);
        send_pulse(32'd100, 1'b1);
        // Both outer additions overflow and must clamp.
        send_pulse(32'hFFFF_FFF0, 1'b0);
        send_pulse(32'h8000_0000, 1'b0);
        send_pulse(32'hFFFF_FFF0, 1'b1);
        // Alternating long and short pulses, so adjustments carry down the track.
        send_pulse(32'd80, 1'b0);
        send_pulse(32'd40, 1'b0);
        send_pulse(32'd80, 1'b0);
        send_pulse(32'd40, 1'b0);
        send_pulse(32'd80, 1'b0);
        send_pulse(32'd40, 1'b1);
    endtask

    // The receiver stalls long enough for the command queue to fill and block the input.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        hold_left     = 300;
        for (int k = 0; k < 24; k++) begin
            send_pulse(pick_width(SHAPE_CELLS, 60), k == 23);
        end
        drain_results(SETTLE_CYCLES);
    endtask

    // The sender stops in the middle of a track until every beat has come out.
    task automatic test_mid_track_pause();
        send_idle_pct = 17;
        recv_idle_pct = 64;
        for (int k = 0; k < 8; k++) begin
            send_pulse(pick_width(SHAPE_CELLS, 120), 1'b0);
        end
        drain_results(SETTLE_CYCLES);
        for (int k = 0; k < 6; k++) begin
            send_pulse(pick_width(SHAPE_CELLS, 120), k == 5);
        end
        drain_results(SETTLE_CYCLES);
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        send_random_tracks(n_items);
        drain_results(SETTLE_CYCLES);
    endtask

    // Receiver: random ready, forced low while a hold-off is counting down.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            comp_if.ready <= 1'b0;
        end else begin
            comp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compares every accepted output beat with the oldest predicted one.
    always @(posedge i_clk) begin
        t_comp_beat want;
        if (i_rst_n && comp_if.valid && comp_if.ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected output beat: out_width %0h, out_last %0b",
                       comp_if.out_width, comp_if.out_last);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (comp_if.out_width !== want.width) begin
                    $error("out_width mismatch: expected %0h, actual %0h",
                           want.width, comp_if.out_width);
                    fail_count++;
                end
                if (comp_if.out_last !== want.last) begin
                    $error("out_last mismatch: expected %0b, actual %0b",
                           want.last, comp_if.out_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        fail_count           = 0;
        cycle_count          = 0;
        hold_left            = 0;
        send_idle_pct        = 17;
        recv_idle_pct        = 64;
        win_older            = '0;
        win_newer            = '0;
        win_held             = HELD_NONE;
        i_rst_n              = 1'b0;
        pulse_if.valid       = 1'b0;
        pulse_if.pulse_width = '0;
        pulse_if.is_last     = 1'b0;
        comp_if.ready        = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_tracks();
        test_unadjusted_tracks();
        test_adjusted_tracks();
        drain_results(SETTLE_CYCLES);
        test_output_backpressure();
        test_mid_track_pause();
        test_random_phase(17, 64, 130);
        test_random_phase(64, 17, 130);
        test_random_phase(0, 0, 130);

        if (fail_count == 0 && expected_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
